// ===== src/imcp_pkg.sv =====
// shared types and constants of the im2col 3x3 panel address generator
// no dependencies; imported by imcp_datapath, imcp_ctrl and the top level
package imcp_pkg;

  localparam int KERNEL_SIZE = 3;
  localparam int KR_W        = $clog2(KERNEL_SIZE);
  localparam logic [KR_W-1:0] K_LAST = KR_W'(KERNEL_SIZE - 1);

  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_STEP  = 1'b1;

  // register indexes, word address paddr[3:2]
  localparam logic [1:0] REG_OUT_WIDTH = 2'd0;
  localparam logic [1:0] REG_IN_HEIGHT = 2'd1;
  localparam logic [1:0] REG_IN_WIDTH  = 2'd2;
  localparam logic [1:0] REG_CH_GROUPS = 2'd3;

  typedef struct packed {
    logic [12:0] out_width;
    logic [12:0] in_height;
    logic [12:0] in_width;
    logic [10:0] channel_groups;
  } imcp_cfg_t;

  typedef struct packed {
    logic load_start;
    logic div_commit;
    logic mul1;
    logic mul2;
    logic emit;
  } imcp_cmd_t;

  typedef struct packed {
    logic busy;
    logic div_done;
    logic out_free;
  } imcp_sts_t;

endpackage

// ===== src/imcp_div.sv =====
// restoring divider, one quotient bit per cycle: pixel index by output width
// depends on nothing outside this file
module imcp_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [23:0] dividend,
  input  logic [12:0] divisor,
  output logic        done,
  output logic [23:0] quot,
  output logic [11:0] rem
);

  logic [23:0] q_r;
  logic [11:0] rem_r;
  logic [12:0] divisor_r;
  logic [4:0]  cnt_r;
  logic        run_r;
  logic        done_r;
  logic [12:0] trial;
  logic        fits;
  logic [12:0] diff;

  assign trial = {rem_r, q_r[23]};
  assign fits  = trial >= divisor_r;
  assign diff  = trial - divisor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        run_r     <= 1'b1;
        cnt_r     <= 5'd24;
        q_r       <= dividend;
        rem_r     <= '0;
        divisor_r <= divisor;
      end else if (run_r) begin
        // remainder stays below the divisor (at most 4096), so at most 4095 and 12 bits hold it
        rem_r <= fits ? diff[11:0] : trial[11:0];
        q_r   <= {q_r[22:0], fits};
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd1) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = q_r;
  assign rem  = rem_r;

endmodule

// ===== src/imcp_datapath.sv =====
// datapath: block position counters, address multipliers, output register
// depends on imcp_pkg and imcp_div
module imcp_datapath #(
  parameter int WIDE_PANEL = 12,
  parameter int TAIL_PANEL = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  imcp_pkg::imcp_cfg_t cfg,
  input  logic [23:0]         start_index,
  input  logic [12:0]         pixel_count,
  input  imcp_pkg::imcp_cmd_t cmd,
  output imcp_pkg::imcp_sts_t sts,
  input  logic                out_stall,
  output logic                out_valid,
  output logic [25:0]         out_dst_offset,
  output logic [31:0]         out_src_addr,
  output logic                out_zero_fill,
  output logic                out_last_move
);
  import imcp_pkg::*;

  localparam int MAX_PANEL = (WIDE_PANEL > TAIL_PANEL) ? WIDE_PANEL : TAIL_PANEL;
  localparam int CIP_W     = $clog2(MAX_PANEL);
  localparam logic [13:0] WIDE14 = 14'(WIDE_PANEL);
  localparam logic [13:0] TAIL14 = 14'(TAIL_PANEL);

  logic              busy_r;
  logic [12:0]       block_len_r;
  logic [12:0]       pfc_r;
  logic [23:0]       psr_r;
  logic [11:0]       psc_r;
  logic [9:0]        kg_r;
  logic [KR_W-1:0]   kr_r;
  logic [KR_W-1:0]   kc_r;
  logic [CIP_W-1:0]  cip_r;
  logic [23:0]       row_r;
  logic [11:0]       col_r;
  logic [25:0]       dst_r;
  logic [12:0]       eff_ow_r;
  logic [10:0]       eff_grp_r;
  logic [22:0]       prod1_r;
  logic [31:0]       prod2_r;
  logic              out_valid_r;
  logic [25:0]       out_dst_r;
  logic [31:0]       out_src_r;
  logic              out_zf_r;
  logic              out_last_r;

  logic [12:0] eff_ow_nxt;
  logic [10:0] grp_sat;
  logic [12:0] bs_sat;
  logic        div_done;
  logic [23:0] div_quot;
  logic [11:0] div_rem;

  logic [13:0] pw;
  logic [13:0] col_j;
  logic [13:0] panel_end;
  logic        zf;
  logic        col_last;
  logic        k_last;
  logic        panel_last;
  logic [22:0] mul1_full;
  logic [24:0] row_sum;
  logic [37:0] mul2_full;
  logic [31:0] addr;
  logic [12:0] ncol_sum;
  logic        col_wrap;
  logic [11:0] ncol;
  logic [23:0] nrow;

  // saturation of sizes taken at block start
  always_comb begin
    if (cfg.out_width == 13'd0) eff_ow_nxt = 13'd1;
    else if (cfg.out_width > 13'd4096) eff_ow_nxt = 13'd4096;
    else eff_ow_nxt = cfg.out_width;
    grp_sat = (cfg.channel_groups > 11'd1024) ? 11'd1024 : cfg.channel_groups;
    bs_sat  = (pixel_count > 13'd4096) ? 13'd4096 : pixel_count;
  end

  imcp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (cmd.load_start),
    .dividend (start_index),
    .divisor  (eff_ow_nxt),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // panel is wide while a whole wide panel still fits in the block
  assign pw         = ({1'b0, pfc_r} + WIDE14 <= {1'b0, block_len_r}) ? WIDE14 : TAIL14;
  assign col_j      = {1'b0, pfc_r} + 14'(cip_r);
  assign zf         = col_j >= {1'b0, block_len_r};
  assign col_last   = 14'(cip_r) + 14'd1 >= pw;
  assign k_last     = ({1'b0, kg_r} + 11'd1 >= eff_grp_r) && (kr_r == K_LAST)
                      && (kc_r == K_LAST);
  assign panel_end  = {1'b0, pfc_r} + pw;
  assign panel_last = panel_end >= {1'b0, block_len_r};

  assign mul1_full = kg_r * cfg.in_height;
  assign row_sum   = 25'(prod1_r) + 25'(row_r) + 25'(kr_r);
  assign mul2_full = row_sum * cfg.in_width;
  assign addr      = prod2_r + 32'(col_r) + 32'(kc_r);

  assign ncol_sum = {1'b0, col_r} + 13'd1;
  assign col_wrap = ncol_sum >= eff_ow_r;
  assign ncol     = col_wrap ? 12'd0 : ncol_sum[11:0];
  assign nrow     = col_wrap ? row_r + 24'd1 : row_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      block_len_r <= '0;
      pfc_r       <= '0;
      psr_r       <= '0;
      psc_r       <= '0;
      kg_r        <= '0;
      kr_r        <= '0;
      kc_r        <= '0;
      cip_r       <= '0;
      row_r       <= '0;
      col_r       <= '0;
      dst_r       <= '0;
      eff_ow_r    <= 13'd1;
      eff_grp_r   <= 11'd1;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load_start) begin
        block_len_r <= bs_sat;
        pfc_r       <= '0;
        kg_r        <= '0;
        kr_r        <= '0;
        kc_r        <= '0;
        cip_r       <= '0;
        dst_r       <= '0;
        eff_ow_r    <= eff_ow_nxt;
        eff_grp_r   <= grp_sat;
        busy_r      <= (bs_sat != 13'd0) && (grp_sat != 11'd0);
      end
      if (cmd.div_commit) begin
        psr_r <= div_quot;
        row_r <= div_quot;
        psc_r <= div_rem;
        col_r <= div_rem;
      end
      if (cmd.emit) begin
        dst_r <= dst_r + 26'd1;
        if (!col_last) begin
          cip_r <= cip_r + CIP_W'(1);
          row_r <= nrow;
          col_r <= ncol;
        end else begin
          cip_r <= '0;
          if (!k_last) begin
            if (kc_r == K_LAST) begin
              kc_r <= '0;
              if (kr_r == K_LAST) begin
                kr_r <= '0;
                kg_r <= kg_r + 10'd1;
              end else begin
                kr_r <= kr_r + KR_W'(1);
              end
            end else begin
              kc_r <= kc_r + KR_W'(1);
            end
            row_r <= psr_r;
            col_r <= psc_r;
          end else begin
            kg_r  <= '0;
            kr_r  <= '0;
            kc_r  <= '0;
            pfc_r <= panel_end[12:0];
            psr_r <= nrow;
            psc_r <= ncol;
            row_r <= nrow;
            col_r <= ncol;
            if (panel_last) busy_r <= 1'b0;
          end
        end
      end
      if (cmd.emit) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul1) prod1_r <= mul1_full;
    if (cmd.mul2) prod2_r <= mul2_full[31:0];
    if (cmd.emit) begin
      out_dst_r  <= dst_r;
      out_src_r  <= zf ? 32'd0 : addr;
      out_zf_r   <= zf;
      out_last_r <= col_last && k_last && panel_last;
    end
  end

  assign sts.busy     = busy_r;
  assign sts.div_done = div_done;
  assign sts.out_free = !out_valid_r || !out_stall;

  assign out_valid      = out_valid_r;
  assign out_dst_offset = out_dst_r;
  assign out_src_addr   = out_src_r;
  assign out_zero_fill  = out_zf_r;
  assign out_last_move  = out_last_r;

`ifndef SYNTHESIS
  a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> busy_r)
    else $error("move emitted with no block in progress");
  a_cip_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> 14'(cip_r) < pw)
    else $error("panel column beyond panel width");
  a_pfc_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> pfc_r < block_len_r)
    else $error("panel start beyond block while busy");
`endif

endmodule

// ===== src/imcp_ctrl.sv =====
// controller: sequences start (divide) and step (two multiplies, emit)
// depends on imcp_pkg
module imcp_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_func,
  output logic                in_stall,
  input  imcp_pkg::imcp_sts_t sts,
  output imcp_pkg::imcp_cmd_t cmd
);
  import imcp_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_MUL1 = 3'd2;
  localparam logic [2:0] S_MUL2 = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       accept;

  assign accept   = in_valid && (state_r == S_IDLE);
  assign in_stall = state_r != S_IDLE;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_func == FUNC_START) begin
            cmd.load_start = 1'b1;
            state_nxt      = S_DIV;
          end else if (sts.busy) begin
            state_nxt = S_MUL1;
          end
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.div_commit = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

`ifndef SYNTHESIS
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.out_free)
    else $error("emit into an occupied output register");
  a_mul_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MUL1 |=> state_r == S_MUL2)
    else $error("second multiply skipped");
  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_done |-> state_r == S_DIV)
    else $error("divider finished outside the start sequence");
`endif

endmodule

// ===== src/im2col_3x3_panel_address_gen_unit.sv =====
// top level of the im2col 3x3 stride-1 panel address generator
// depends on imcp_pkg, imcp_ctrl, imcp_datapath (and imcp_div below it)
//
// usage:
//   configure out_width, in_height, in_width, channel_groups over the apb
//   port (byte addresses 0, 4, 8, 12) while the block is idle.
//   input channel (in_valid / in_stall): func 0 starts a block from
//   start_index covering pixel_count pixels and gives no move; func 1 asks
//   for the next word move, which is dropped when no block is in progress.
//   output channel (out_valid / out_stall): one move per step transaction,
//   ascending dst_offset, last_move set on the final one.
// sequence:
//   start transaction: the next input is taken only once the bit-serial
//   divide of the 24-bit start_index by out_width has finished.
//   step transaction: passes the states MUL1, MUL2 and EMIT, for the two
//   chained multiplies of the source address, each registered; an idle step skips them.
//   result is registered in the output register in EMIT, after both multiplies.
// stall: a finished move waits in the output register; the controller
//   holds in_stall high until that register frees up for the next one.
// reset: rst_n (synchronous) returns the control, counter and configuration
//   registers to their defaults and leaves the block idle with no move pending.
module im2col_3x3_panel_address_gen_unit #(
  parameter int WIDE_PANEL = 12,
  parameter int TAIL_PANEL = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_func,
  input  logic [23:0] in_start_index,
  input  logic [12:0] in_pixel_count,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [25:0] out_dst_offset,
  output logic [31:0] out_src_addr,
  output logic        out_zero_fill,
  output logic        out_last_move,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import imcp_pkg::*;

  imcp_cfg_t cfg_r;
  imcp_cmd_t cmd;
  imcp_sts_t sts;
  logic      cfg_wr;

  // write completes in the access phase; no wait states
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // register index is the word address paddr[3:2]
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.out_width      <= 13'd1;
      cfg_r.in_height      <= 13'd3;
      cfg_r.in_width       <= 13'd3;
      cfg_r.channel_groups <= 11'd1;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_OUT_WIDTH: cfg_r.out_width      <= pwdata[12:0];
        REG_IN_HEIGHT: cfg_r.in_height      <= pwdata[12:0];
        REG_IN_WIDTH:  cfg_r.in_width       <= pwdata[12:0];
        REG_CH_GROUPS: cfg_r.channel_groups <= pwdata[10:0];
      endcase
    end
  end

  // readback of the register selected by paddr
  always_comb begin
    unique case (paddr[3:2])
      REG_OUT_WIDTH: prdata = 32'(cfg_r.out_width);
      REG_IN_HEIGHT: prdata = 32'(cfg_r.in_height);
      REG_IN_WIDTH:  prdata = 32'(cfg_r.in_width);
      REG_CH_GROUPS: prdata = 32'(cfg_r.channel_groups);
    endcase
  end

  // sequencer: accepts transactions, issues commands
  imcp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_func),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // counters, multipliers, divider and output register
  imcp_datapath #(
    .WIDE_PANEL (WIDE_PANEL),
    .TAIL_PANEL (TAIL_PANEL)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .start_index    (in_start_index),
    .pixel_count    (in_pixel_count),
    .cmd            (cmd),
    .sts            (sts),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_dst_offset (out_dst_offset),
    .out_src_addr   (out_src_addr),
    .out_zero_fill  (out_zero_fill),
    .out_last_move  (out_last_move)
  );

endmodule
